/* rtl/fmd_pkg.sv */
package fmd_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLES_PER_BIT_DEF = 44;
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int FIFO_DEPTH_DEF      = 4;

   // Tone synthesis constants
   localparam logic [63:0] RATE_HZ  = 64'd44100;
   localparam logic [63:0] TONE0_HZ = 64'd2000;
   localparam logic [63:0] TONE1_HZ = 64'd4000;
   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] ONE_Q30  = 64'd1073741824;

   localparam int REF_W        = 16;
   localparam int ACC_W        = 37;
   localparam int MAG_W        = ACC_W + 1;
   localparam int CONF_W       = 16;
   localparam int BIT_W        = 12;
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_IDX_W  = 8;

   // Register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BITS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_BITS = 1'b1;
   localparam logic [BIT_W-1:0] FRAME_BITS_RST   = 12'd1208;
   localparam logic [BIT_W-1:0] PAYLOAD_BITS_RST = 12'd1200;

   typedef logic [TABLE_DEPTH-1:0][REF_W-1:0] tone_table_type;

   // One finished bit group, handed from the accumulator to the decision stage
   typedef struct packed {
      logic signed [ACC_W-1:0] low_sum;
      logic signed [ACC_W-1:0] high_sum;
      logic [BIT_W-1:0]        bit_index;
      logic                    is_check;
      logic                    frame_last;
   } bit_rec_type;

   // sin(2*pi*hz*pos/RATE_HZ) in Q1.15: angle folded into the first quadrant,
   // Horner series through x^11/11! in Q30
   function automatic logic signed [REF_W-1:0] tone_ref(input logic [63:0] hz,
                                                        input logic [63:0] pos);
      logic [63:0] k;
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] r;
      logic        neg;
      k = (hz * pos) % RATE_HZ;
      m = 64'd2 * k;
      neg = 1'b0;
      if (m >= RATE_HZ) begin
         neg = 1'b1;
         m = 64'd2 * RATE_HZ - m;
      end
      if (64'd2 * m > RATE_HZ) m = RATE_HZ - m;
      x  = (m * PI_Q30 + RATE_HZ / 2) / RATE_HZ;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) r = 64'd32767;
      return neg ? -REF_W'(r) : REF_W'(r);
   endfunction

   function automatic tone_table_type tone_table(input logic [63:0] hz);
      tone_table_type tbl;
      for (int p = 0; p < TABLE_DEPTH; p++) begin
         tbl[p] = tone_ref(hz, 64'(p));
      end
      return tbl;
   endfunction

endpackage

/* rtl/fmd_fifo.sv */
module fmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign count    = count_ff;
   assign empty    = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < CNT_W'(DEPTH))
      else $error("beat pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

/* rtl/fmd_front.sv */
module fmd_front #(
   parameter int SAMPLES_PER_BIT = fmd_pkg::SAMPLES_PER_BIT_DEF,
   parameter int SAMPLE_WIDTH    = fmd_pkg::SAMPLE_WIDTH_DEF,
   parameter int FIFO_DEPTH      = fmd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic                              req_frame_start,
   input  logic [fmd_pkg::BIT_W-1:0]         frame_bits,
   input  logic [fmd_pkg::BIT_W-1:0]         payload_bits,
   input  logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count,
   output logic                              push,
   output fmd_pkg::bit_rec_type              push_rec
);
   import fmd_pkg::*;

   localparam int POS_W  = $clog2(SAMPLES_PER_BIT);
   localparam int PROD_W = SAMPLE_WIDTH + REF_W;
   localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int CRED_W = CNT_W + 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_BIT - 1);
   localparam tone_table_type LOW_TABLE  = tone_table(TONE0_HZ);
   localparam tone_table_type HIGH_TABLE = tone_table(TONE1_HZ);

   typedef struct packed {
      logic             start;
      logic             grp_end;
      logic [BIT_W-1:0] bit_index;
      logic             is_check;
      logic             frame_last;
   } tag_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
      if ((v[SUM_W-1:ACC_W-1] == '0) || (v[SUM_W-1:ACC_W-1] == '1)) return v[ACC_W-1:0];
      else if (v[SUM_W-1]) return {1'b1, {(ACC_W-1){1'b0}}};
      else return {1'b0, {(ACC_W-1){1'b1}}};
   endfunction

   logic                    active_ff, active_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;

   logic                    a_valid_ff, a_valid_in;
   tag_type                 a_tag_ff, a_tag_in;
   logic signed [SAMPLE_WIDTH-1:0] a_sample_ff;
   logic signed [REF_W-1:0] a_ref0_ff, a_ref0_in;
   logic signed [REF_W-1:0] a_ref1_ff, a_ref1_in;

   logic                    b_valid_ff;
   tag_type                 b_tag_ff;
   logic signed [PROD_W-1:0] b_prod0_ff, b_prod0_in;
   logic signed [PROD_W-1:0] b_prod1_ff, b_prod1_in;

   logic signed [ACC_W-1:0] acc0_ff, acc0_in;
   logic signed [ACC_W-1:0] acc1_ff, acc1_in;

   logic                    accept, take;
   logic [POS_W-1:0]        pos_cur;
   logic [BIT_W-1:0]        bit_cur;
   logic [TABLE_IDX_W-1:0]  tbl_idx;
   logic [CRED_W-1:0]       credit;
   logic signed [ACC_W-1:0] base0, base1;
   logic signed [SUM_W-1:0] sum0, sum1;
   logic signed [ACC_W-1:0] sat0, sat1;

   // Reserve a queue slot for every group end still in the pipeline
   assign credit = CRED_W'(fifo_count) + CRED_W'(a_valid_ff && a_tag_ff.grp_end)
                 + CRED_W'(b_valid_ff && b_tag_ff.grp_end);
   assign req_stall = (credit >= CRED_W'(FIFO_DEPTH));

   always_comb begin
      accept = req_valid && !req_stall;
      take   = accept && (req_frame_start || active_ff);
      pos_cur = req_frame_start ? '0 : pos_ff;
      bit_cur = req_frame_start ? '0 : bit_ff;

      a_tag_in.start      = req_frame_start;
      a_tag_in.grp_end    = (pos_cur == POS_LAST);
      a_tag_in.bit_index  = bit_cur;
      a_tag_in.is_check   = (bit_cur >= payload_bits);
      a_tag_in.frame_last = ((BIT_W+1)'(bit_cur) + 1'b1) >= (BIT_W+1)'(frame_bits);

      active_in = active_ff;
      pos_in    = pos_ff;
      bit_in    = bit_ff;
      if (take) begin
         active_in = !(a_tag_in.grp_end && a_tag_in.frame_last);
         pos_in    = a_tag_in.grp_end ? '0 : pos_cur + 1'b1;
         bit_in    = (a_tag_in.grp_end && !a_tag_in.frame_last) ? bit_cur + 1'b1 : bit_cur;
      end

      tbl_idx    = TABLE_IDX_W'(pos_cur);
      a_valid_in = take;
      a_ref0_in  = LOW_TABLE[tbl_idx];
      a_ref1_in  = HIGH_TABLE[tbl_idx];

      b_prod0_in = PROD_W'(a_sample_ff) * PROD_W'(a_ref0_ff);
      b_prod1_in = PROD_W'(a_sample_ff) * PROD_W'(a_ref1_ff);

      // Accumulate; a frame start drops any partial group
      base0 = b_tag_ff.start ? '0 : acc0_ff;
      base1 = b_tag_ff.start ? '0 : acc1_ff;
      sum0  = SUM_W'(base0) + SUM_W'(b_prod0_ff);
      sum1  = SUM_W'(base1) + SUM_W'(b_prod1_ff);
      sat0  = sat_acc(sum0);
      sat1  = sat_acc(sum1);
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      if (b_valid_ff) begin
         acc0_in = b_tag_ff.grp_end ? '0 : sat0;
         acc1_in = b_tag_ff.grp_end ? '0 : sat1;
      end

      push                = b_valid_ff && b_tag_ff.grp_end;
      push_rec.low_sum    = sat0;
      push_rec.high_sum   = sat1;
      push_rec.bit_index  = b_tag_ff.bit_index;
      push_rec.is_check   = b_tag_ff.is_check;
      push_rec.frame_last = b_tag_ff.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pos_ff     <= '0;
         bit_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         pos_ff     <= pos_in;
         bit_ff     <= bit_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
      a_tag_ff    <= a_tag_in;
      a_sample_ff <= req_sample;
      a_ref0_ff   <= a_ref0_in;
      a_ref1_ff   <= a_ref1_in;
      b_tag_ff    <= a_tag_ff;
      b_prod0_ff  <= b_prod0_in;
      b_prod1_ff  <= b_prod1_in;
      acc0_ff     <= acc0_in;
      acc1_ff     <= acc1_in;
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit <= CRED_W'(FIFO_DEPTH))
      else $error("group ends in flight exceed queue space");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_frame_start)
      |=> (a_valid_ff && a_tag_ff.start && a_tag_ff.bit_index == '0))
      else $error("frame start beat did not restart the bit count");

endmodule

/* rtl/fmd_back.sv */
module fmd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fifo_empty,
   input  fmd_pkg::bit_rec_type            pop_rec,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_bit_value,
   output logic signed [fmd_pkg::ACC_W-1:0] rsp_low_tone_corr,
   output logic signed [fmd_pkg::ACC_W-1:0] rsp_high_tone_corr,
   output logic [fmd_pkg::CONF_W-1:0]      rsp_confidence,
   output logic [fmd_pkg::BIT_W-1:0]       rsp_bit_index,
   output logic                            rsp_is_check_bit,
   output logic                            rsp_frame_last
);
   import fmd_pkg::*;

   localparam int REM_W  = MAG_W + 1;
   localparam int STEP_W = $clog2(CONF_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CONF_W - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_HOLD} state_type;

   state_type            state_ff, state_in;
   bit_rec_type          rec_ff, rec_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [MAG_W-1:0]     den_ff, den_in;
   logic [CONF_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_bit_ff, out_bit_in;
   logic signed [ACC_W-1:0] out_low_ff, out_low_in;
   logic signed [ACC_W-1:0] out_high_ff, out_high_in;
   logic [CONF_W-1:0]    out_conf_ff, out_conf_in;
   logic [BIT_W-1:0]     out_index_ff, out_index_in;
   logic                 out_check_ff, out_check_in;
   logic                 out_last_ff, out_last_in;

   logic signed [MAG_W-1:0] diff;
   logic [MAG_W-1:0]     mag_d, mag_h, mag_l, den_sum;
   logic [REM_W-1:0]     shifted, den_ext, sub;
   logic                 ge, out_free;

   always_comb begin
      pop = (state_ff == ST_IDLE) && !fifo_empty;

      diff    = MAG_W'(rec_ff.high_sum) - MAG_W'(rec_ff.low_sum);
      mag_d   = diff[MAG_W-1] ? -diff : diff;
      mag_h   = rec_ff.high_sum[ACC_W-1] ? -MAG_W'(rec_ff.high_sum) : MAG_W'(rec_ff.high_sum);
      mag_l   = rec_ff.low_sum[ACC_W-1] ? -MAG_W'(rec_ff.low_sum) : MAG_W'(rec_ff.low_sum);
      den_sum = mag_h + mag_l;

      // One restoring step per cycle; the remainder stays below the divisor
      shifted = {rem_ff, 1'b0};
      den_ext = {1'b0, den_ff};
      ge      = (shifted >= den_ext);
      sub     = shifted - den_ext;

      out_free = !out_valid_ff || !rsp_stall;

      state_in     = state_ff;
      rec_in       = rec_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_bit_in   = out_bit_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      out_conf_in  = out_conf_ff;
      out_index_in = out_index_ff;
      out_check_in = out_check_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rec_in   = pop_rec;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            den_in  = den_sum;
            rem_in  = mag_d;
            quo_in  = '0;
            step_in = '0;
            if (den_sum == '0) begin
               state_in = ST_HOLD;
            end else if (mag_d == den_sum) begin
               quo_in   = '1;
               state_in = ST_HOLD;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? sub[MAG_W-1:0] : shifted[MAG_W-1:0];
            quo_in  = {quo_ff[CONF_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_bit_in   = (rec_ff.high_sum > rec_ff.low_sum);
               out_low_in   = rec_ff.low_sum;
               out_high_in  = rec_ff.high_sum;
               out_conf_in  = quo_ff;
               out_index_in = rec_ff.bit_index;
               out_check_in = rec_ff.is_check;
               out_last_in  = rec_ff.frame_last;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rec_ff       <= rec_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      out_bit_ff   <= out_bit_in;
      out_low_ff   <= out_low_in;
      out_high_ff  <= out_high_in;
      out_conf_ff  <= out_conf_in;
      out_index_ff <= out_index_in;
      out_check_ff <= out_check_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_bit_value      = out_bit_ff;
   assign rsp_low_tone_corr  = out_low_ff;
   assign rsp_high_tone_corr = out_high_ff;
   assign rsp_confidence     = out_conf_ff;
   assign rsp_bit_index      = out_index_ff;
   assign rsp_is_check_bit   = out_check_ff;
   assign rsp_frame_last     = out_last_ff;

   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0 && rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_beat_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_HOLD))
      else $error("result beat raised outside the hold state");

endmodule

/* rtl/fsk_matched_filter_demodulator_unit.sv */
// Binary FSK correlation demodulator.
// Input channel (req_*): one audio sample per beat, req_frame_start marks the first
// sample of a frame. Samples arriving outside a frame without a start flag are dropped.
// Each group of SAMPLES_PER_BIT samples is correlated against the 2 kHz and 4 kHz
// reference tones; one result beat (rsp_*) follows each completed group with the
// decided bit, both correlations, a Q0.16 confidence, the bit index and the flags.
// Configuration (csr_*): frame_bits at index 0, payload_bits at index 1; write only
// while no group is in flight.
// Throughput: one sample per cycle while req_stall is low. The decision stage handles each bit
// in order (queue pop, magnitude load, 16 radix-2 divider steps, output load), or skips
// the divide when both sums are zero or |c1-c0| equals |c1|+|c0|, and takes no new
// bit before the last one has left; when groups end faster than it retires them,
// req_stall rises once the bit queue fills.
// Reset clears the frame, position and bit counters, empties the pipeline and the
// queue and loads frame_bits = 1208, payload_bits = 1200.
// A stalled result beat holds; the sample pipeline keeps running until the queue
// plus groups in flight reach the queue depth, then req_stall asserts.
module fsk_matched_filter_demodulator_unit #(
   parameter int SAMPLES_PER_BIT = fmd_pkg::SAMPLES_PER_BIT_DEF,
   parameter int SAMPLE_WIDTH    = fmd_pkg::SAMPLE_WIDTH_DEF,
   parameter int FIFO_DEPTH      = fmd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_bit_value,
   output logic signed [fmd_pkg::ACC_W-1:0]  rsp_low_tone_corr,
   output logic signed [fmd_pkg::ACC_W-1:0]  rsp_high_tone_corr,
   output logic [fmd_pkg::CONF_W-1:0]        rsp_confidence,
   output logic [fmd_pkg::BIT_W-1:0]         rsp_bit_index,
   output logic                              rsp_is_check_bit,
   output logic                              rsp_frame_last,
   input  logic                              csr_wr_en,
   input  logic [fmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmd_pkg::BIT_W-1:0]         csr_wdata
);
   import fmd_pkg::*;

   localparam int REC_W = $bits(bit_rec_type);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [BIT_W-1:0] frame_bits_ff, frame_bits_in;
   logic [BIT_W-1:0] payload_bits_ff, payload_bits_in;

   logic             push, pop, fifo_empty;
   bit_rec_type      push_rec, pop_rec;
   logic [REC_W-1:0] fifo_rd_data;
   logic [CNT_W-1:0] fifo_count;

   always_comb begin
      frame_bits_in   = frame_bits_ff;
      payload_bits_in = payload_bits_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_FRAME_BITS) frame_bits_in = csr_wdata;
         else if (csr_index == CSR_PAYLOAD_BITS) payload_bits_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff   <= FRAME_BITS_RST;
         payload_bits_ff <= PAYLOAD_BITS_RST;
      end else begin
         frame_bits_ff   <= frame_bits_in;
         payload_bits_ff <= payload_bits_in;
      end
   end

   fmd_front #(
      .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .FIFO_DEPTH      (FIFO_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .frame_bits      (frame_bits_ff),
      .payload_bits    (payload_bits_ff),
      .fifo_count      (fifo_count),
      .push            (push),
      .push_rec        (push_rec)
   );

   fmd_fifo #(
      .WIDTH (REC_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_rec),
      .pop       (pop),
      .pop_data  (fifo_rd_data),
      .count     (fifo_count),
      .empty     (fifo_empty)
   );

   assign pop_rec = bit_rec_type'(fifo_rd_data);

   fmd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .fifo_empty         (fifo_empty),
      .pop_rec            (pop_rec),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_low_tone_corr  (rsp_low_tone_corr),
      .rsp_high_tone_corr (rsp_high_tone_corr),
      .rsp_confidence     (rsp_confidence),
      .rsp_bit_index      (rsp_bit_index),
      .rsp_is_check_bit   (rsp_is_check_bit),
      .rsp_frame_last     (rsp_frame_last)
   );

endmodule

/* verif/fsk_matched_filter_demodulator_unit_tb.sv */
module fsk_matched_filter_demodulator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SPB = fmd_pkg::SAMPLES_PER_BIT_DEF;
   localparam int SW  = fmd_pkg::SAMPLE_WIDTH_DEF;
   localparam int AW  = fmd_pkg::ACC_W;
   localparam longint ACC_MAX = (64'sd1 <<< (AW - 1)) - 64'sd1;
   localparam longint ACC_MIN = -(64'sd1 <<< (AW - 1));
   localparam int PHASES = 8;

   typedef struct {
      logic signed [SW-1:0] smp;
      logic                 start;
   } audio_beat_type;

   typedef struct {
      logic                          bit_value;
      logic signed [AW-1:0]          low_corr;
      logic signed [AW-1:0]          high_corr;
      logic [fmd_pkg::CONF_W-1:0]    confidence;
      logic [fmd_pkg::BIT_W-1:0]     bit_index;
      logic                          is_check;
      logic                          frame_last;
   } bit_decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_sample = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_bit_value;
   logic signed [AW-1:0] rsp_low_tone_corr;
   logic signed [AW-1:0] rsp_high_tone_corr;
   logic [fmd_pkg::CONF_W-1:0] rsp_confidence;
   logic [fmd_pkg::BIT_W-1:0] rsp_bit_index;
   logic rsp_is_check_bit;
   logic rsp_frame_last;
   logic csr_wr_en = 1'b0;
   logic [fmd_pkg::CSR_IDX_W-1:0] csr_index = fmd_pkg::CSR_FRAME_BITS;
   logic [fmd_pkg::BIT_W-1:0] csr_wdata = '0;

   fsk_matched_filter_demodulator_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_low_tone_corr  (rsp_low_tone_corr),
      .rsp_high_tone_corr (rsp_high_tone_corr),
      .rsp_confidence     (rsp_confidence),
      .rsp_bit_index      (rsp_bit_index),
      .rsp_is_check_bit   (rsp_is_check_bit),
      .rsp_frame_last     (rsp_frame_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tone references and demodulator state mirrored by the testbench
   logic signed [15:0] low_ref [SPB];
   logic signed [15:0] high_ref [SPB];
   logic [fmd_pkg::BIT_W-1:0] frame_len_cfg = fmd_pkg::FRAME_BITS_RST;
   logic [fmd_pkg::BIT_W-1:0] payload_len_cfg = fmd_pkg::PAYLOAD_BITS_RST;
   int unsigned group_pos = 0;
   int unsigned bit_num = 0;
   longint low_acc = 0;
   longint high_acc = 0;
   bit in_frame = 1'b0;

   audio_beat_type samples_to_send[$];
   bit_decision_type bits_due[$];
   int queued_cnt = 0;
   int accepted_cnt = 0;
   int fail_cnt = 0;
   bit calm = 1'b0;
   int send_gap = 0;
   int hold_left = 0;
   audio_beat_type next_beat;
   bit_decision_type want;

   // Q1.15 sine of 2*pi*hz*pos/rate: fold into the first quadrant, then the
   // odd series to x^11 evaluated inside out with Q30 truncation
   function automatic logic signed [15:0] sine_q15(input longint unsigned hz,
                                                   input longint unsigned pos);
      longint unsigned ang;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned acc;
      longint unsigned rounded;
      longint unsigned divisor [5];
      bit negate;
      divisor = '{110, 72, 42, 20, 6};
      ang = 2 * ((hz * pos) % fmd_pkg::RATE_HZ);
      negate = (ang >= fmd_pkg::RATE_HZ);
      if (negate) ang = 2 * fmd_pkg::RATE_HZ - ang;
      if (2 * ang > fmd_pkg::RATE_HZ) ang = fmd_pkg::RATE_HZ - ang;
      x = (ang * fmd_pkg::PI_Q30 + fmd_pkg::RATE_HZ / 2) / fmd_pkg::RATE_HZ;
      x2 = (x * x) >> 30;
      acc = fmd_pkg::ONE_Q30;
      foreach (divisor[i]) acc = fmd_pkg::ONE_Q30 - ((x2 * acc) >> 30) / divisor[i];
      rounded = ((((x * acc) >> 30) * 32768) + (64'd1 << 29)) >> 30;
      if (rounded > 32767) rounded = 32767;
      return negate ? -16'(rounded) : 16'(rounded);
   endfunction

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // fold one accepted sample into the correlators, queue a decision per full group
   task automatic absorb_sample(input logic signed [SW-1:0] smp, input logic start);
      longint unsigned diff;
      longint unsigned denom;
      longint unsigned ratio;
      bit_decision_type d;
      bit ends;
      if (start) begin
         group_pos = 0;
         bit_num = 0;
         low_acc = 0;
         high_acc = 0;
         in_frame = 1'b1;
      end
      if (!in_frame) return;
      low_acc = clamp_acc(low_acc + longint'(smp) * longint'(low_ref[group_pos]));
      high_acc = clamp_acc(high_acc + longint'(smp) * longint'(high_ref[group_pos]));
      group_pos++;
      if (group_pos < SPB) return;
      diff = (high_acc > low_acc) ? high_acc - low_acc : low_acc - high_acc;
      denom = ((high_acc < 0) ? -high_acc : high_acc) + ((low_acc < 0) ? -low_acc : low_acc);
      ratio = 0;
      if (denom != 0) begin
         ratio = (diff << 16) / denom;
         if (ratio > 65535) ratio = 65535;
      end
      ends = (bit_num + 1 >= frame_len_cfg);
      d.bit_value = (high_acc > low_acc);
      d.low_corr = AW'(low_acc);
      d.high_corr = AW'(high_acc);
      d.confidence = 16'(ratio);
      d.bit_index = 12'(bit_num);
      d.is_check = (bit_num >= payload_len_cfg);
      d.frame_last = ends;
      bits_due = {bits_due, d};
      group_pos = 0;
      low_acc = 0;
      high_acc = 0;
      if (ends) in_frame = 1'b0;
      else bit_num = (bit_num + 1) & 12'hFFF;
   endtask

   task automatic queue_sample(input logic signed [SW-1:0] v, input logic start);
      audio_beat_type b;
      b.smp = v;
      b.start = start;
      samples_to_send = {samples_to_send, b};
      queued_cnt++;
   endtask

   // one frame of nbits groups, cut short after keep samples
   task automatic queue_frame(input int nbits, input int keep);
      int mode;
      int emitted;
      bit neg;
      logic signed [15:0] v;
      emitted = 0;
      for (int b = 0; b < nbits; b++) begin
         mode = $urandom_range(0, 9);
         neg = $urandom_range(0, 1);
         for (int p = 0; p < SPB; p++) begin
            if (emitted == keep) return;
            case (mode)
               4: v = '0;
               5: v = neg ? -low_ref[p] : low_ref[p];
               6: v = neg ? -high_ref[p] : high_ref[p];
               7: v = (low_ref[p] >>> 1) + (high_ref[p] >>> 1)
                      + $signed(16'($urandom_range(0, 63))) - 16'sd32;
               8: v = neg ? 16'sh8000 : 16'sh7fff;
               9: v = $signed(16'($urandom_range(0, 15))) - 16'sd8;
               default: v = 16'($urandom);
            endcase
            queue_sample(v, (b == 0 && p == 0));
            emitted++;
         end
      end
   endtask

   task automatic write_reg(input logic [fmd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fmd_pkg::BIT_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == fmd_pkg::CSR_FRAME_BITS) frame_len_cfg = val;
      else payload_len_cfg = val;
   endtask

   task automatic wait_idle(input int settle);
      while (accepted_cnt != queued_cnt || bits_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // sample driver: advance only when the current beat is taken or none is up
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_sample(req_sample, req_frame_start);
            accepted_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               next_beat = samples_to_send.pop_front();
               req_sample <= next_beat.smp;
               req_frame_start <= next_beat.start;
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bits_due.size() == 0) begin
               $error("result beat with no bit decision pending");
               fail_cnt++;
            end else begin
               want = bits_due.pop_front();
               if (rsp_bit_value !== want.bit_value) begin
                  $error("bit_value expected %0d got %0d", want.bit_value, rsp_bit_value);
                  fail_cnt++;
               end
               if (rsp_low_tone_corr !== want.low_corr) begin
                  $error("low_tone_corr expected %0d got %0d", want.low_corr,
                         rsp_low_tone_corr);
                  fail_cnt++;
               end
               if (rsp_high_tone_corr !== want.high_corr) begin
                  $error("high_tone_corr expected %0d got %0d", want.high_corr,
                         rsp_high_tone_corr);
                  fail_cnt++;
               end
               if (rsp_confidence !== want.confidence) begin
                  $error("confidence expected %0d got %0d", want.confidence, rsp_confidence);
                  fail_cnt++;
               end
               if (rsp_bit_index !== want.bit_index) begin
                  $error("bit_index expected %0d got %0d", want.bit_index, rsp_bit_index);
                  fail_cnt++;
               end
               if (rsp_is_check_bit !== want.is_check) begin
                  $error("is_check_bit expected %0d got %0d", want.is_check,
                         rsp_is_check_bit);
                  fail_cnt++;
               end
               if (rsp_frame_last !== want.frame_last) begin
                  $error("frame_last expected %0d got %0d", want.frame_last, rsp_frame_last);
                  fail_cnt++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            hold_left = pick_gap();
         end
      end
   end

   initial begin
      int frame_sel [PHASES];
      int payload_sel [PHASES];
      int goal;
      int nb;
      int r;
      frame_sel = '{1, 3, 0, 4095, 2, 5, 1, 4095};
      payload_sel = '{0, 1, 4095, 2, 2, 3, 0, 4095};
      for (int p = 0; p < SPB; p++) begin
         low_ref[p] = sine_q15(fmd_pkg::TONE0_HZ, p);
         high_ref[p] = sine_q15(fmd_pkg::TONE1_HZ, p);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no frame open yet: extremes are dropped
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7fff, 1'b0);
      queue_sample(16'sh0000, 1'b0);
      queue_sample(16'shffff, 1'b0);
      queue_sample(16'sh0001, 1'b0);
      // open a frame, then restart it mid-group
      queue_sample(16'sh7fff, 1'b1);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'shffff, 1'b0);
      queue_sample(16'sh0000, 1'b0);
      queue_sample(16'sh5555, 1'b0);
      queue_sample(16'sh8000, 1'b1);
      queue_sample(16'sh7fff, 1'b0);
      queue_sample(16'shaaaa, 1'b0);
      queue_sample(16'sh0001, 1'b0);
      queue_sample(16'sh8001, 1'b0);
      wait_idle(40);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 2) begin
            frame_sel[ph] = $urandom_range(1, 6);
            payload_sel[ph] = $urandom_range(0, 6);
         end
         write_reg(fmd_pkg::CSR_FRAME_BITS, 12'(frame_sel[ph]));
         write_reg(fmd_pkg::CSR_PAYLOAD_BITS, 12'(payload_sel[ph]));
         calm = (ph == 2 || ph == 5);
         goal = queued_cnt + 235;
         while (queued_cnt < goal) begin
            nb = (frame_len_cfg == 0) ? 1 : frame_len_cfg;
            if (nb > 6) nb = $urandom_range(1, 4);
            r = $urandom_range(0, 99);
            if (r < 8) begin
               repeat ($urandom_range(1, 6)) queue_sample(16'($urandom), 1'b0);
            end else if (r < 18) begin
               queue_frame(nb, $urandom_range(1, nb * SPB - 1));
            end else begin
               queue_frame(nb, nb * SPB);
            end
         end
         wait_idle(40);
      end

      wait_idle(60);
      if (fail_cnt == 0 && bits_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
